// ===== rtl/core/cpu4_pkg.sv =====
// Package with the shared types, opcode codes and helper functions of the 4-bit execute unit.
`default_nettype none
package cpu4_pkg;

    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned PAIR_COUNT = REG_COUNT / 2;

    localparam logic [3:0] OPR_NOP = 4'h0;
    localparam logic [3:0] OPR_JCN = 4'h1;
    localparam logic [3:0] OPR_FIM = 4'h2;
    localparam logic [3:0] OPR_FIN = 4'h3;
    localparam logic [3:0] OPR_JUN = 4'h4;
    localparam logic [3:0] OPR_JMS = 4'h5;
    localparam logic [3:0] OPR_INC = 4'h6;
    localparam logic [3:0] OPR_ISZ = 4'h7;
    localparam logic [3:0] OPR_ADD = 4'h8;
    localparam logic [3:0] OPR_SUB = 4'h9;
    localparam logic [3:0] OPR_LD  = 4'hA;
    localparam logic [3:0] OPR_XCH = 4'hB;
    localparam logic [3:0] OPR_BBL = 4'hC;
    localparam logic [3:0] OPR_LDM = 4'hD;
    localparam logic [3:0] OPR_IO  = 4'hE;
    localparam logic [3:0] OPR_ACC = 4'hF;

    // I/O group operands.
    localparam logic [3:0] IO_WRM = 4'h0;
    localparam logic [3:0] IO_WMP = 4'h1;
    localparam logic [3:0] IO_WRR = 4'h2;
    localparam logic [3:0] IO_WPM = 4'h3;
    localparam logic [3:0] IO_WR0 = 4'h4;
    localparam logic [3:0] IO_WR1 = 4'h5;
    localparam logic [3:0] IO_WR2 = 4'h6;
    localparam logic [3:0] IO_WR3 = 4'h7;
    localparam logic [3:0] IO_SBM = 4'h8;
    localparam logic [3:0] IO_RDM = 4'h9;
    localparam logic [3:0] IO_RDR = 4'hA;
    localparam logic [3:0] IO_ADM = 4'hB;

    // Accumulator group operands.
    localparam logic [3:0] AC_CLB = 4'h0;
    localparam logic [3:0] AC_CLC = 4'h1;
    localparam logic [3:0] AC_IAC = 4'h2;
    localparam logic [3:0] AC_CMC = 4'h3;
    localparam logic [3:0] AC_CMA = 4'h4;
    localparam logic [3:0] AC_RAL = 4'h5;
    localparam logic [3:0] AC_RAR = 4'h6;
    localparam logic [3:0] AC_TCC = 4'h7;
    localparam logic [3:0] AC_DAC = 4'h8;
    localparam logic [3:0] AC_TCS = 4'h9;
    localparam logic [3:0] AC_STC = 4'hA;
    localparam logic [3:0] AC_DAA = 4'hB;
    localparam logic [3:0] AC_KBP = 4'hC;
    localparam logic [3:0] AC_DCL = 4'hD;

    typedef enum logic [2:0] {
        BUS_NONE   = 3'd0,
        BUS_SRC    = 3'd1,
        BUS_BANK   = 3'd2,
        BUS_RAMWR  = 3'd3,
        BUS_RAMPRT = 3'd4,
        BUS_ROMPRT = 3'd5,
        BUS_STATWR = 3'd6
    } bus_op_t;

    // One decoded instruction word as it sits in the queue between front and back.
    typedef struct packed {
        logic [3:0] opr;
        logic [3:0] opa;
        logic [7:0] b2;
        logic [3:0] rd;
        logic [7:0] tb;
        logic       tp;
        logic [1:0] ticks;
    } dec_t;

    localparam logic [3:0] DAA_LIMIT = 4'd9;
    localparam logic [3:0] DAA_ADJ   = 4'd6;
    localparam logic [3:0] TCS_SET   = 4'hA;
    localparam logic [3:0] TCS_CLR   = 4'h9;

    function automatic logic [3:0] key_decode(input logic [3:0] a);
        logic [3:0] r;
        begin
            case (a)
                4'h0:    r = 4'h0;
                4'h1:    r = 4'h1;
                4'h2:    r = 4'h2;
                4'h4:    r = 4'h3;
                4'h8:    r = 4'h4;
                default: r = 4'hF;
            endcase
            return r;
        end
    endfunction

    function automatic logic [1:0] tick_count(input logic [3:0] opr, input logic [3:0] opa);
        logic [1:0] t;
        begin
            case (opr)
                OPR_JCN, OPR_JUN, OPR_JMS, OPR_ISZ: t = 2'd2;
                OPR_FIM, OPR_FIN: t = opa[0] ? 2'd1 : 2'd2;
                OPR_ACC: t = (opa > AC_DCL) ? 2'd0 : 2'd1;
                default: t = 2'd1;
            endcase
            return t;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cpu4_front.sv =====
// Front end: classifies incoming instruction words and holds them in a two-entry queue.
`default_nettype none
module cpu4_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    opcode_byte,
    input  wire logic [7:0]    second_byte,
    input  wire logic [3:0]    read_nibble,
    input  wire logic [7:0]    table_byte,
    input  wire logic          test_pin,
    output logic               q_valid,
    output cpu4_pkg::dec_t     q_word,
    input  wire logic          q_take
);

    cpu4_pkg::dec_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    cpu4_pkg::dec_t in_word;
    logic           do_push, do_pop;

    always_comb
    begin
        in_word.opr   = opcode_byte[7:4];
        in_word.opa   = opcode_byte[3:0];
        in_word.b2    = second_byte;
        in_word.rd    = read_nibble;
        in_word.tb    = table_byte;
        in_word.tp    = test_pin;
        in_word.ticks = cpu4_pkg::tick_count(opcode_byte[7:4], opcode_byte[3:0]);
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_word  = q_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/cpu4_back.sv =====
// Back end: holds machine state, runs one instruction a cycle unless stalled, registers the result.
`default_nettype none
module cpu4_back #(
    parameter int unsigned STACK_LEVELS = 3
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire cpu4_pkg::dec_t q_word,
    output logic                q_take,
    output logic                empty,
    input  wire logic           pop,
    output logic [11:0]         next_pc,
    output logic [3:0]          acc_value,
    output logic                carry_value,
    output logic [7:0]          pair_zero,
    output logic [2:0]          bus_op,
    output logic [7:0]          bus_data,
    output logic [1:0]          status_index,
    output logic [1:0]          ticks_used
);

    localparam int unsigned SPW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
    localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_LEVELS - 1);
    localparam int unsigned PW = $clog2(cpu4_pkg::PAIR_COUNT);

    logic [3:0]  acc_reg, acc_next;
    logic        carry_reg, carry_next;
    logic [11:0] pc_reg, pc_next;
    logic [7:0]  pairs_reg [cpu4_pkg::PAIR_COUNT];
    logic [11:0] stack_reg [STACK_LEVELS];
    logic [SPW-1:0] sp_reg, sp_next;
    logic        out_valid_reg;

    logic [11:0] out_pc_reg;
    logic [3:0]  out_acc_reg;
    logic        out_carry_reg;
    logic [7:0]  out_pz_reg;
    logic [2:0]  out_bus_reg;
    logic [7:0]  out_data_reg;
    logic [1:0]  out_sidx_reg;
    logic [1:0]  out_ticks_reg;

    logic [3:0]  opr, opa;
    logic [PW-1:0] prow_idx;
    logic [7:0]  prow, row_new;
    logic [3:0]  rv, rv_inc;
    logic        row_we;
    logic [11:0] pc1, pc2;
    logic [SPW-1:0] sp_dec;
    logic        push_en;
    logic [11:0] push_val;
    logic        cond;
    logic [4:0]  sum;
    logic [2:0]  bus_next;
    logic [7:0]  data_next;
    logic [1:0]  sidx_next;
    logic [7:0]  pz_next;
    logic        exec;

    assign exec   = q_valid && (!out_valid_reg || pop);
    assign q_take = exec;
    assign empty  = !out_valid_reg;

    assign opr      = q_word.opr;
    assign opa      = q_word.opa;
    assign prow_idx = opa[3:1];
    assign prow     = pairs_reg[prow_idx];
    assign rv       = opa[0] ? prow[3:0] : prow[7:4];
    assign rv_inc   = rv + 4'd1;
    assign pc1      = pc_reg + 12'd1;
    assign pc2      = pc_reg + 12'd2;
    assign sp_dec   = (sp_reg == '0) ? SP_LAST : sp_reg - SPW'(1);

    always_comb
    begin
        acc_next  = acc_reg;
        carry_next = carry_reg;
        pc_next   = pc1;
        sp_next   = sp_reg;
        row_we    = 1'b0;
        row_new   = prow;
        push_en   = 1'b0;
        push_val  = pc2;
        bus_next  = cpu4_pkg::BUS_NONE;
        data_next = 8'd0;
        sidx_next = 2'd0;
        cond      = 1'b0;
        sum       = 5'd0;
        case (opr)
            cpu4_pkg::OPR_JCN:
            begin
                cond = (opa[2] && acc_reg == 4'd0) || (opa[1] && carry_reg)
                       || (opa[0] && !q_word.tp);
                pc_next = (cond ^ opa[3]) ? {pc2[11:8], q_word.b2} : pc2;
            end
            cpu4_pkg::OPR_FIM:
            begin
                if (opa[0])
                begin
                    bus_next  = cpu4_pkg::BUS_SRC;
                    data_next = prow;
                end
                else
                begin
                    pc_next = pc2;
                    row_we  = 1'b1;
                    row_new = q_word.b2;
                end
            end
            cpu4_pkg::OPR_FIN:
            begin
                if (opa[0])
                begin
                    pc_next = {pc1[11:8], prow};
                end
                else
                begin
                    row_we  = 1'b1;
                    row_new = q_word.tb;
                end
            end
            cpu4_pkg::OPR_JUN: pc_next = {opa, q_word.b2};
            cpu4_pkg::OPR_JMS:
            begin
                push_en = 1'b1;
                sp_next = (sp_reg == SP_LAST) ? '0 : sp_reg + SPW'(1);
                pc_next = {opa, q_word.b2};
            end
            cpu4_pkg::OPR_INC, cpu4_pkg::OPR_ISZ:
            begin
                row_we  = 1'b1;
                row_new = opa[0] ? {prow[7:4], rv_inc} : {rv_inc, prow[3:0]};
                if (opr == cpu4_pkg::OPR_ISZ)
                begin
                    pc_next = (rv_inc != 4'd0) ? {pc2[11:8], q_word.b2} : pc2;
                end
            end
            cpu4_pkg::OPR_ADD:
            begin
                sum = {1'b0, acc_reg} + {1'b0, rv} + {4'd0, carry_reg};
                acc_next = sum[3:0];
                carry_next = sum[4];
            end
            cpu4_pkg::OPR_SUB:
            begin
                sum = {1'b0, acc_reg} + {1'b0, ~rv} + {4'd0, ~carry_reg};
                acc_next = sum[3:0];
                carry_next = sum[4];
            end
            cpu4_pkg::OPR_LD: acc_next = rv;
            cpu4_pkg::OPR_XCH:
            begin
                acc_next = rv;
                row_we   = 1'b1;
                row_new  = opa[0] ? {prow[7:4], acc_reg} : {acc_reg, prow[3:0]};
            end
            cpu4_pkg::OPR_BBL:
            begin
                acc_next = opa;
                sp_next  = sp_dec;
                pc_next  = stack_reg[sp_dec];
            end
            cpu4_pkg::OPR_LDM: acc_next = opa;
            cpu4_pkg::OPR_IO:
            begin
                case (opa)
                    cpu4_pkg::IO_WRM:
                    begin
                        bus_next = cpu4_pkg::BUS_RAMWR;
                        data_next = {4'd0, acc_reg};
                    end
                    cpu4_pkg::IO_WMP:
                    begin
                        bus_next = cpu4_pkg::BUS_RAMPRT;
                        data_next = {4'd0, acc_reg};
                    end
                    cpu4_pkg::IO_WRR:
                    begin
                        bus_next = cpu4_pkg::BUS_ROMPRT;
                        data_next = {4'd0, acc_reg};
                    end
                    cpu4_pkg::IO_WPM: ;
                    cpu4_pkg::IO_WR0, cpu4_pkg::IO_WR1, cpu4_pkg::IO_WR2, cpu4_pkg::IO_WR3:
                    begin
                        bus_next = cpu4_pkg::BUS_STATWR;
                        data_next = {4'd0, acc_reg};
                        sidx_next = opa[1:0];
                    end
                    cpu4_pkg::IO_SBM:
                    begin
                        sum = {1'b0, acc_reg} + {1'b0, ~q_word.rd} + {4'd0, ~carry_reg};
                        acc_next = sum[3:0];
                        carry_next = sum[4];
                    end
                    cpu4_pkg::IO_RDM, cpu4_pkg::IO_RDR: acc_next = q_word.rd;
                    cpu4_pkg::IO_ADM:
                    begin
                        sum = {1'b0, acc_reg} + {1'b0, q_word.rd} + {4'd0, carry_reg};
                        acc_next = sum[3:0];
                        carry_next = sum[4];
                    end
                    default:
                    begin
                        acc_next = q_word.rd;
                        sidx_next = opa[1:0];
                    end
                endcase
            end
            cpu4_pkg::OPR_ACC:
            begin
                case (opa)
                    cpu4_pkg::AC_CLB:
                    begin
                        acc_next = 4'd0;
                        carry_next = 1'b0;
                    end
                    cpu4_pkg::AC_CLC: carry_next = 1'b0;
                    cpu4_pkg::AC_IAC:
                    begin
                        sum = {1'b0, acc_reg} + 5'd1;
                        acc_next = sum[3:0];
                        carry_next = sum[4];
                    end
                    cpu4_pkg::AC_CMC: carry_next = ~carry_reg;
                    cpu4_pkg::AC_CMA: acc_next = ~acc_reg;
                    cpu4_pkg::AC_RAL:
                    begin
                        carry_next = acc_reg[3];
                        acc_next = {acc_reg[2:0], carry_reg};
                    end
                    cpu4_pkg::AC_RAR:
                    begin
                        carry_next = acc_reg[0];
                        acc_next = {carry_reg, acc_reg[3:1]};
                    end
                    cpu4_pkg::AC_TCC:
                    begin
                        acc_next = {3'd0, carry_reg};
                        carry_next = 1'b0;
                    end
                    cpu4_pkg::AC_DAC:
                    begin
                        carry_next = (acc_reg != 4'd0);
                        acc_next = acc_reg - 4'd1;
                    end
                    cpu4_pkg::AC_TCS:
                    begin
                        acc_next = carry_reg ? cpu4_pkg::TCS_SET : cpu4_pkg::TCS_CLR;
                        carry_next = 1'b0;
                    end
                    cpu4_pkg::AC_STC: carry_next = 1'b1;
                    cpu4_pkg::AC_DAA:
                    begin
                        if (acc_reg > cpu4_pkg::DAA_LIMIT || carry_reg)
                        begin
                            sum = {1'b0, acc_reg} + {1'b0, cpu4_pkg::DAA_ADJ};
                            acc_next = sum[3:0];
                            carry_next = carry_reg | sum[4];
                        end
                    end
                    cpu4_pkg::AC_KBP: acc_next = cpu4_pkg::key_decode(acc_reg);
                    cpu4_pkg::AC_DCL:
                    begin
                        bus_next = cpu4_pkg::BUS_BANK;
                        data_next = {5'd0, acc_reg[2:0]};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        pz_next = (row_we && prow_idx == '0) ? row_new : pairs_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 4'd0;
            carry_reg     <= 1'b0;
            pc_reg        <= 12'd0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < int'(cpu4_pkg::PAIR_COUNT); i++)
            begin
                pairs_reg[i] <= 8'd0;
            end
            for (int i = 0; i < int'(STACK_LEVELS); i++)
            begin
                stack_reg[i] <= 12'd0;
            end
        end
        else
        begin
            if (exec)
            begin
                acc_reg   <= acc_next;
                carry_reg <= carry_next;
                pc_reg    <= pc_next;
                sp_reg    <= sp_next;
                if (row_we)
                begin
                    pairs_reg[prow_idx] <= row_new;
                end
                if (push_en)
                begin
                    stack_reg[sp_reg] <= push_val;
                end
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_pc_reg    <= pc_next;
            out_acc_reg   <= acc_next;
            out_carry_reg <= carry_next;
            out_pz_reg    <= pz_next;
            out_bus_reg   <= bus_next;
            out_data_reg  <= data_next;
            out_sidx_reg  <= sidx_next;
            out_ticks_reg <= q_word.ticks;
        end
    end

    assign next_pc      = out_pc_reg;
    assign acc_value    = out_acc_reg;
    assign carry_value  = out_carry_reg;
    assign pair_zero    = out_pz_reg;
    assign bus_op       = out_bus_reg;
    assign bus_data     = out_data_reg;
    assign status_index = out_sidx_reg;
    assign ticks_used   = out_ticks_reg;

endmodule
`default_nettype wire

// ===== rtl/core/four_bit_cpu_execute_unit.sv =====
// Top level of the 4-bit CPU execute unit: front queue feeding the executing back end.
//
// Usage: the unit executes one instruction word per input word. The input side
// looks like a queue: drive the fetched bytes, the read nibble, the table byte and
// the test pin, and raise push; the word is taken at a clock edge where full is low.
// The output side looks like a queue too: while empty is low, the oldest result word
// (next pc, accumulator, carry, register pair zero, bus operation and tick count) is
// on the result ports, and it is taken at an edge where pop is high.
// The word lands in the two-entry front queue at the accepting edge, then executes
// from there into the result register once that register is free.
// Throughput is one word per cycle while the receiver keeps popping.
// When the receiver stalls, the result register holds, the back end stops, and the
// front queue absorbs up to two more words before full rises.
// Reset clears the accumulator, carry, index registers, program counter, return
// stack and stack pointer at once, and empties both queues.
`default_nettype none
module four_bit_cpu_execute_unit #(
    parameter int unsigned STACK_LEVELS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  opcode_byte,
    input  wire logic [7:0]  second_byte,
    input  wire logic [3:0]  read_nibble,
    input  wire logic [7:0]  table_byte,
    input  wire logic        test_pin,
    output logic             empty,
    input  wire logic        pop,
    output logic [11:0]      next_pc,
    output logic [3:0]       acc_value,
    output logic             carry_value,
    output logic [7:0]       pair_zero,
    output logic [2:0]       bus_op,
    output logic [7:0]       bus_data,
    output logic [1:0]       status_index,
    output logic [1:0]       ticks_used
);

    logic           q_valid;
    logic           q_take;
    cpu4_pkg::dec_t q_word;

    cpu4_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode_byte (opcode_byte),
        .second_byte (second_byte),
        .read_nibble (read_nibble),
        .table_byte  (table_byte),
        .test_pin    (test_pin),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_take      (q_take)
    );

    cpu4_back #(
        .STACK_LEVELS (STACK_LEVELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_take       (q_take),
        .empty        (empty),
        .pop          (pop),
        .next_pc      (next_pc),
        .acc_value    (acc_value),
        .carry_value  (carry_value),
        .pair_zero    (pair_zero),
        .bus_op       (bus_op),
        .bus_data     (bus_data),
        .status_index (status_index),
        .ticks_used   (ticks_used)
    );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the 4-bit CPU execute unit with a built-in instruction predictor.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 3;

    // One expected result word, held in order until the unit hands it out.
    typedef struct packed {
        logic [11:0]       pc;
        logic [3:0]        acc;
        logic              cy;
        logic [7:0]        p0;
        cpu4_pkg::bus_op_t op;
        logic [7:0]        data;
        logic [1:0]        sidx;
        logic [1:0]        ticks;
    } exec_word_t;

    // One directed instruction; chk marks rows whose result is typed in by hand.
    typedef struct {
        logic [7:0] opb;
        logic [7:0] b2;
        logic [3:0] rd;
        logic [7:0] tbl;
        logic       tp;
        bit         chk;
        exec_word_t want;
    } insn_row_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  opcode_byte;
    logic [7:0]  second_byte;
    logic [3:0]  read_nibble;
    logic [7:0]  table_byte;
    logic        test_pin;
    logic        empty;
    logic        pop;
    logic [11:0] next_pc;
    logic [3:0]  acc_value;
    logic        carry_value;
    logic [7:0]  pair_zero;
    logic [2:0]  bus_op;
    logic [7:0]  bus_data;
    logic [1:0]  status_index;
    logic [1:0]  ticks_used;

    four_bit_cpu_execute_unit #(.STACK_LEVELS(STACK_DEPTH)) DUT (.*);

    // Predictor state: a private copy of the machine registers.
    logic [3:0]  m_acc;
    logic        m_cy;
    logic [3:0]  m_regs [16];
    logic [11:0] m_pc;
    logic [11:0] m_stack [STACK_DEPTH];
    int          m_sp;

    exec_word_t pending_words [$];
    int  errors;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  sent_count;
    bit  hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Fixed ceiling on the run; generous against the slowest legal pace.
    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [7:0] pair_of(input logic [3:0] opa);
        return {m_regs[{opa[3:1], 1'b0}], m_regs[{opa[3:1], 1'b1}]};
    endfunction

    // Executes one instruction on the private state and returns the word it produces.
    function automatic exec_word_t execute_insn(input logic [7:0] opb, input logic [7:0] b2,
                                                input logic [3:0] rd, input logic [7:0] tbl,
                                                input logic tp);
        exec_word_t w;
        logic [3:0] opr;
        logic [3:0] opa;
        logic [11:0] pc;
        logic [4:0] sum;
        logic [3:0] tmp;
        logic cond;
        opr = opb[7:4];
        opa = opb[3:0];
        w = '0;
        w.op = cpu4_pkg::BUS_NONE;
        w.ticks = 2'd1;
        pc = m_pc + 12'd1;
        case (opr)
            cpu4_pkg::OPR_NOP: ;
            cpu4_pkg::OPR_JCN:
            begin
                pc = pc + 12'd1;
                cond = (opa[2] && m_acc == 4'd0) || (opa[1] && m_cy) || (opa[0] && !tp);
                if (opa[3])
                    cond = !cond;
                if (cond)
                    pc[7:0] = b2;
                w.ticks = 2'd2;
            end
            cpu4_pkg::OPR_FIM:
                if (opa[0])
                begin
                    w.op = cpu4_pkg::BUS_SRC;
                    w.data = pair_of(opa);
                end
                else
                begin
                    pc = pc + 12'd1;
                    m_regs[{opa[3:1], 1'b0}] = b2[7:4];
                    m_regs[{opa[3:1], 1'b1}] = b2[3:0];
                    w.ticks = 2'd2;
                end
            cpu4_pkg::OPR_FIN:
                if (opa[0])
                    pc[7:0] = pair_of(opa);
                else
                begin
                    m_regs[{opa[3:1], 1'b0}] = tbl[7:4];
                    m_regs[{opa[3:1], 1'b1}] = tbl[3:0];
                    w.ticks = 2'd2;
                end
            cpu4_pkg::OPR_JUN:
            begin
                pc = {opa, b2};
                w.ticks = 2'd2;
            end
            cpu4_pkg::OPR_JMS:
            begin
                pc = pc + 12'd1;
                m_stack[m_sp] = pc;
                m_sp = (m_sp + 1) % STACK_DEPTH;
                pc = {opa, b2};
                w.ticks = 2'd2;
            end
            cpu4_pkg::OPR_INC: m_regs[opa] = m_regs[opa] + 4'd1;
            cpu4_pkg::OPR_ISZ:
            begin
                pc = pc + 12'd1;
                m_regs[opa] = m_regs[opa] + 4'd1;
                if (m_regs[opa] != 4'd0)
                    pc[7:0] = b2;
                w.ticks = 2'd2;
            end
            cpu4_pkg::OPR_ADD:
            begin
                sum = m_acc + m_regs[opa] + m_cy;
                {m_cy, m_acc} = sum;
            end
            cpu4_pkg::OPR_SUB:
            begin
                // The complement is taken on four bits before the sum widens.
                sum = {1'b0, m_acc} + {1'b0, ~m_regs[opa]} + {4'd0, !m_cy};
                {m_cy, m_acc} = sum;
            end
            cpu4_pkg::OPR_LD: m_acc = m_regs[opa];
            cpu4_pkg::OPR_XCH:
            begin
                tmp = m_acc;
                m_acc = m_regs[opa];
                m_regs[opa] = tmp;
            end
            cpu4_pkg::OPR_BBL:
            begin
                m_acc = opa;
                m_sp = (m_sp + STACK_DEPTH - 1) % STACK_DEPTH;
                pc = m_stack[m_sp];
            end
            cpu4_pkg::OPR_LDM: m_acc = opa;
            cpu4_pkg::OPR_IO:
                case (opa)
                    cpu4_pkg::IO_WRM:
                    begin
                        w.op = cpu4_pkg::BUS_RAMWR;
                        w.data = {4'd0, m_acc};
                    end
                    cpu4_pkg::IO_WMP:
                    begin
                        w.op = cpu4_pkg::BUS_RAMPRT;
                        w.data = {4'd0, m_acc};
                    end
                    cpu4_pkg::IO_WRR:
                    begin
                        w.op = cpu4_pkg::BUS_ROMPRT;
                        w.data = {4'd0, m_acc};
                    end
                    cpu4_pkg::IO_WPM: ;
                    cpu4_pkg::IO_WR0, cpu4_pkg::IO_WR1, cpu4_pkg::IO_WR2, cpu4_pkg::IO_WR3:
                    begin
                        w.op = cpu4_pkg::BUS_STATWR;
                        w.data = {4'd0, m_acc};
                        w.sidx = opa[1:0];
                    end
                    cpu4_pkg::IO_SBM:
                    begin
                        sum = {1'b0, m_acc} + {1'b0, ~rd} + {4'd0, !m_cy};
                        {m_cy, m_acc} = sum;
                    end
                    cpu4_pkg::IO_RDM, cpu4_pkg::IO_RDR: m_acc = rd;
                    cpu4_pkg::IO_ADM:
                    begin
                        sum = m_acc + rd + m_cy;
                        {m_cy, m_acc} = sum;
                    end
                    default:
                    begin
                        m_acc = rd;
                        w.sidx = opa[1:0];
                    end
                endcase
            default:
                case (opa)
                    cpu4_pkg::AC_CLB: begin m_acc = 4'd0; m_cy = 1'b0; end
                    cpu4_pkg::AC_CLC: m_cy = 1'b0;
                    cpu4_pkg::AC_IAC:
                    begin
                        sum = m_acc + 5'd1;
                        {m_cy, m_acc} = sum;
                    end
                    cpu4_pkg::AC_CMC: m_cy = !m_cy;
                    cpu4_pkg::AC_CMA: m_acc = ~m_acc;
                    cpu4_pkg::AC_RAL: {m_cy, m_acc} = {m_acc, m_cy};
                    cpu4_pkg::AC_RAR: {m_acc, m_cy} = {m_cy, m_acc};
                    cpu4_pkg::AC_TCC: begin m_acc = {3'd0, m_cy}; m_cy = 1'b0; end
                    cpu4_pkg::AC_DAC:
                    begin
                        m_cy = (m_acc != 4'd0);
                        m_acc = m_acc - 4'd1;
                    end
                    cpu4_pkg::AC_TCS:
                    begin
                        m_acc = m_cy ? cpu4_pkg::TCS_SET : cpu4_pkg::TCS_CLR;
                        m_cy = 1'b0;
                    end
                    cpu4_pkg::AC_STC: m_cy = 1'b1;
                    cpu4_pkg::AC_DAA:
                        if (m_acc > cpu4_pkg::DAA_LIMIT || m_cy)
                        begin
                            sum = m_acc + cpu4_pkg::DAA_ADJ;
                            if (sum[4])
                                m_cy = 1'b1;
                            m_acc = sum[3:0];
                        end
                    cpu4_pkg::AC_KBP:
                        case (m_acc)
                            4'h0, 4'h1, 4'h2: ;
                            4'h4: m_acc = 4'h3;
                            4'h8: m_acc = 4'h4;
                            default: m_acc = 4'hF;
                        endcase
                    cpu4_pkg::AC_DCL:
                    begin
                        w.op = cpu4_pkg::BUS_BANK;
                        w.data = {5'd0, m_acc[2:0]};
                    end
                    default: w.ticks = 2'd0;
                endcase
        endcase
        m_pc = pc;
        w.pc = pc;
        w.acc = m_acc;
        w.cy = m_cy;
        w.p0 = {m_regs[0], m_regs[1]};
        return w;
    endfunction

    // Offers one instruction word, honoring the sender idle rate, and waits for acceptance.
    task automatic offer_word(input logic [7:0] opb, input logic [7:0] b2, input logic [3:0] rd,
                              input logic [7:0] tbl, input logic tp, input bit chk,
                              input exec_word_t want);
        exec_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        opcode_byte <= opb;
        second_byte <= b2;
        read_nibble <= rd;
        table_byte <= tbl;
        test_pin <= tp;
        do
            @(posedge clk);
        while (full);
        sent_count++;
        w = execute_insn(opb, b2, rd, tbl, tp);
        // A hand-typed row must agree with the predictor itself.
        if (chk && w !== want)
        begin
            $display("%0t: directed row %h expected %h, predictor %h", $time, opb, want, w);
            errors++;
        end
        pending_words.push_back(w);
    endtask

    task automatic drop_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // Random instructions weighted toward pair loads, calls, returns, accumulator and I/O operations.
    task automatic random_insn();
        logic [7:0] opb;
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            opb = {cpu4_pkg::OPR_FIM, 3'($urandom), 1'b0};
        else if (sel < 20)
            opb = {cpu4_pkg::OPR_JMS, 4'($urandom)};
        else if (sel < 30)
            opb = {cpu4_pkg::OPR_BBL, 4'($urandom)};
        else if (sel < 45)
            opb = {cpu4_pkg::OPR_ACC, 4'($urandom_range(13))};
        else if (sel < 55)
            opb = {cpu4_pkg::OPR_IO, 4'($urandom)};
        else
            opb = 8'($urandom);
        offer_word(opb, 8'($urandom), 4'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // Receiver: pops at a random rate, and holds off entirely while hold_off is set.
    initial
    begin
        exec_word_t exp_w;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: unexpected word pc=%h", $time, next_pc);
                    errors++;
                end
                else
                begin
                    exp_w = pending_words.pop_front();
                    if (next_pc !== exp_w.pc || acc_value !== exp_w.acc ||
                        carry_value !== exp_w.cy || pair_zero !== exp_w.p0 ||
                        bus_op !== exp_w.op || bus_data !== exp_w.data ||
                        status_index !== exp_w.sidx || ticks_used !== exp_w.ticks)
                    begin
                        $display({"%0t: mismatch expected pc=%h a=%h c=%b p0=%h",
                                  " op=%0d d=%h s=%0d t=%0d"},
                                 $time, exp_w.pc, exp_w.acc, exp_w.cy, exp_w.p0, exp_w.op,
                                 exp_w.data, exp_w.sidx, exp_w.ticks);
                        $display({"%0t:          actual   pc=%h a=%h c=%b p0=%h",
                                  " op=%0d d=%h s=%0d t=%0d"},
                                 $time, next_pc, acc_value, carry_value, pair_zero, bus_op,
                                 bus_data, status_index, ticks_used);
                        errors++;
                    end
                end
            end
            pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted in cycles here, while the sender keeps pushing.
    initial
    begin
        @(posedge rst_n);
        wait (sent_count >= 300);
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
    end

    insn_row_t dir_rows [$];

    function automatic exec_word_t mk(input logic [11:0] pc, input logic [3:0] a, input logic c,
                                      input logic [7:0] p0, input cpu4_pkg::bus_op_t op,
                                      input logic [7:0] d, input logic [1:0] s,
                                      input logic [1:0] t);
        return '{pc, a, c, p0, op, d, s, t};
    endfunction

    initial
    begin
        int n;
        errors = 0;
        sent_count = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push <= 1'b0;
        opcode_byte <= '0;
        second_byte <= '0;
        read_nibble <= '0;
        table_byte <= '0;
        test_pin <= 1'b0;
        m_acc = '0;
        m_cy = 1'b0;
        m_pc = '0;
        m_sp = 0;
        foreach (m_regs[i]) m_regs[i] = '0;
        foreach (m_stack[i]) m_stack[i] = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: hand-typed results after reset, then rows left to the predictor: jumps, calls, returns.
        dir_rows = '{
            '{8'h00, 8'hFF, 4'hF, 8'hFF, 1'b1, 1,
              mk(12'h001, 4'h0, 0, 8'h00, cpu4_pkg::BUS_NONE, 0, 0, 1)},
            '{8'hFE, 8'h00, 4'h0, 8'h00, 1'b0, 1,
              mk(12'h002, 4'h0, 0, 8'h00, cpu4_pkg::BUS_NONE, 0, 0, 0)},
            '{8'hFF, 8'h00, 4'h0, 8'h00, 1'b0, 1,
              mk(12'h003, 4'h0, 0, 8'h00, cpu4_pkg::BUS_NONE, 0, 0, 0)},
            '{8'h20, 8'hA5, 4'h0, 8'h00, 1'b0, 1,
              mk(12'h005, 4'h0, 0, 8'hA5, cpu4_pkg::BUS_NONE, 0, 0, 2)},
            '{8'h21, 8'h00, 4'h0, 8'h00, 1'b0, 1,
              mk(12'h006, 4'h0, 0, 8'hA5, cpu4_pkg::BUS_SRC, 8'hA5, 0, 1)},
            '{8'hDF, 8'h00, 4'h0, 8'h00, 1'b0, 1,
              mk(12'h007, 4'hF, 0, 8'hA5, cpu4_pkg::BUS_NONE, 0, 0, 1)},
            '{8'hF2, 8'h00, 4'h0, 8'h00, 1'b0, 1,
              mk(12'h008, 4'h0, 1, 8'hA5, cpu4_pkg::BUS_NONE, 0, 0, 1)},
            '{8'h14, 8'h40, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h1C, 8'h80, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h11, 8'hC0, 4'h0, 8'h00, 1'b1, 0, '0},
            '{8'h19, 8'h10, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h30, 8'h00, 4'h0, 8'hFF, 1'b0, 0, '0},
            '{8'h31, 8'h00, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h4F, 8'hFF, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h5F, 8'hFE, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h50, 8'h10, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h51, 8'h20, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h52, 8'h30, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'hC1, 8'h00, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'hC2, 8'h00, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'hC3, 8'h00, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'hC4, 8'h00, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'h7F, 8'h55, 4'h0, 8'h00, 1'b0, 0, '0},
            '{8'hEB, 8'h00, 4'hF, 8'h00, 1'b0, 0, '0},
            '{8'hFB, 8'h00, 4'h0, 8'h00, 1'b0, 0, '0}
        };
        foreach (dir_rows[i])
            offer_word(dir_rows[i].opb, dir_rows[i].b2, dir_rows[i].rd, dir_rows[i].tbl,
                       dir_rows[i].tp, dir_rows[i].chk, dir_rows[i].want);
        // Every opcode value once, so each operation and operand is reached.
        for (n = 0; n < 256; n++)
            offer_word(8'(n), 8'($urandom), 4'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);

        // Random phases: free running, sender idle, receiver stalling, both.
        for (n = 0; n < 500; n++)
        begin
            case (n / 125)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            random_insn();
        end
        drop_push();

        n = 0;
        while (pending_words.size() != 0 && n < 100000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_words.size() == 0 && empty)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/cpu4_pkg.sv
rtl/core/cpu4_front.sv
rtl/core/cpu4_back.sv
rtl/core/four_bit_cpu_execute_unit.sv
tb/tb.sv
